// File: sv/altwq_pkg.sv
// shared types and constants for the address lock table with wait queue
package altwq_pkg;

  localparam int LOCK_ENTRIES_DEF = 16;
  localparam int WAIT_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 32;
  localparam int REQ_BITS_DEF     = 8;

  localparam logic [1:0] ACT_LOCK   = 2'd0;
  localparam logic [1:0] ACT_UNLOCK = 2'd1;
  localparam logic [1:0] ACT_SQUASH = 2'd2;

  typedef enum logic [3:0] {
    ST_GRANTED     = 4'd0,
    ST_QUEUED      = 4'd1,
    ST_RELEASED    = 4'd2,
    ST_HANDOFF     = 4'd3,
    ST_SQUASHED    = 4'd4,
    ST_SQUASH_MISS = 4'd5,
    ST_UNLOCK_ERR  = 4'd6,
    ST_LOCK_FULL   = 4'd7,
    ST_WAIT_FULL   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GRANT,
    OP_ENQUEUE,
    OP_RELEASE,
    OP_HANDOFF,
    OP_SQUASH
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    search;
    logic    update;
    op_t     op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       lock_hit;
    logic       lock_free;
    logic       wait_full;
    logic       wait_hit;
    logic       squash_hit;
  } dp_stat_t;

endpackage

// File: sv/altwq_dp.sv
// datapath: request registers, lock table, compacting wait queue and result register
module altwq_dp import altwq_pkg::*; #(
  parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
  parameter int WAIT_ENTRIES = WAIT_ENTRIES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int REQ_BITS     = REQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [REQ_BITS-1:0]  in_requester,
  input  logic                 in_has_requester,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [3:0]           out_status,
  output logic                 out_grant_valid,
  output logic [ADDR_BITS-1:0] out_grant_address,
  output logic [REQ_BITS-1:0]  out_grant_requester,
  output logic                 out_grant_has_requester
);

  localparam int CNT_W = $clog2(WAIT_ENTRIES + 1);

  logic [1:0]           act_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [REQ_BITS-1:0]  req_r;
  logic                 has_r;

  logic [LOCK_ENTRIES-1:0] lock_used_r;
  logic [ADDR_BITS-1:0]    lock_addr_r [LOCK_ENTRIES];

  logic [ADDR_BITS-1:0] wait_addr_r [WAIT_ENTRIES];
  logic [REQ_BITS-1:0]  wait_req_r  [WAIT_ENTRIES];
  logic                 wait_has_r  [WAIT_ENTRIES];
  logic [CNT_W-1:0]     wait_cnt_r;

  logic [LOCK_ENTRIES-1:0] lock_hit_r, lock_hit_nxt;
  logic [LOCK_ENTRIES-1:0] lock_free_r, lock_free_nxt;
  logic [WAIT_ENTRIES-1:0] wait_hit_r, wait_hit_nxt;
  logic [WAIT_ENTRIES-1:0] sq_hit_r, sq_hit_nxt;

  logic [LOCK_ENTRIES-1:0] free_sel;
  logic [WAIT_ENTRIES-1:0] wait_src;
  logic [WAIT_ENTRIES-1:0] wait_sel;
  logic [WAIT_ENTRIES-1:0] shift_mask;
  logic [REQ_BITS-1:0]     sel_req;
  logic                    sel_has;
  logic                    do_drop;
  logic                    do_enq;
  logic                    grant;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      addr_r <= in_address;
      req_r  <= in_requester;
      has_r  <= in_has_requester;
    end
  end

  // parallel compare against every table and queue entry
  always_comb begin
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      lock_hit_nxt[i] = lock_used_r[i] && (lock_addr_r[i] == addr_r);
    end
    lock_free_nxt = ~lock_used_r;
    for (int j = 0; j < WAIT_ENTRIES; j++) begin
      wait_hit_nxt[j] = (CNT_W'(j) < wait_cnt_r) && (wait_addr_r[j] == addr_r);
      sq_hit_nxt[j]   = wait_hit_nxt[j] &&
                        (!has_r || (wait_has_r[j] && (wait_req_r[j] == req_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      lock_hit_r  <= lock_hit_nxt;
      lock_free_r <= lock_free_nxt;
      wait_hit_r  <= wait_hit_nxt;
      sq_hit_r    <= sq_hit_nxt;
    end
  end

  // lowest-set-bit selection and waiter readout
  always_comb begin
    free_sel   = lock_free_r & (~lock_free_r + LOCK_ENTRIES'(1));
    wait_src   = (cmd.op == OP_HANDOFF) ? wait_hit_r : sq_hit_r;
    wait_sel   = wait_src & (~wait_src + WAIT_ENTRIES'(1));
    shift_mask = ~(wait_sel - WAIT_ENTRIES'(1));
    sel_req    = '0;
    sel_has    = 1'b0;
    for (int j = 0; j < WAIT_ENTRIES; j++) begin
      if (wait_sel[j]) begin
        sel_req = sel_req | wait_req_r[j];
        sel_has = sel_has | wait_has_r[j];
      end
    end
    do_drop = cmd.update && ((cmd.op == OP_HANDOFF) || (cmd.op == OP_SQUASH));
    do_enq  = cmd.update && (cmd.op == OP_ENQUEUE);
    grant   = (cmd.op == OP_GRANT) || (cmd.op == OP_HANDOFF);
  end

  always_comb begin
    stat.action     = act_r;
    stat.lock_hit   = |lock_hit_r;
    stat.lock_free  = |lock_free_r;
    stat.wait_full  = (wait_cnt_r == CNT_W'(WAIT_ENTRIES));
    stat.wait_hit   = |wait_hit_r;
    stat.squash_hit = |sq_hit_r;
  end

  // lock table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_used_r <= '0;
    end else if (cmd.update) begin
      case (cmd.op)
        OP_GRANT:   lock_used_r <= lock_used_r | free_sel;
        OP_RELEASE: lock_used_r <= lock_used_r & ~lock_hit_r;
        default:    lock_used_r <= lock_used_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      if (cmd.update && (cmd.op == OP_GRANT) && free_sel[i]) begin
        lock_addr_r[i] <= addr_r;
      end
    end
  end

  // wait queue fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_cnt_r <= '0;
    end else if (do_enq) begin
      wait_cnt_r <= wait_cnt_r + CNT_W'(1);
    end else if (do_drop) begin
      wait_cnt_r <= wait_cnt_r - CNT_W'(1);
    end
  end

  // wait queue lanes: append at the tail, close the gap on removal
  for (genvar j = 0; j < WAIT_ENTRIES; j++) begin : g_lane
    if (j < WAIT_ENTRIES - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (do_enq && (CNT_W'(j) == wait_cnt_r)) begin
          wait_addr_r[j] <= addr_r;
          wait_req_r[j]  <= req_r;
          wait_has_r[j]  <= has_r;
        end else if (do_drop && shift_mask[j]) begin
          wait_addr_r[j] <= wait_addr_r[j+1];
          wait_req_r[j]  <= wait_req_r[j+1];
          wait_has_r[j]  <= wait_has_r[j+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (do_enq && (CNT_W'(j) == wait_cnt_r)) begin
          wait_addr_r[j] <= addr_r;
          wait_req_r[j]  <= req_r;
          wait_has_r[j]  <= has_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status              <= cmd.status;
      out_grant_valid         <= grant;
      out_grant_address       <= grant ? addr_r : '0;
      out_grant_requester     <= (cmd.op == OP_GRANT)   ? req_r :
                                 (cmd.op == OP_HANDOFF) ? sel_req : '0;
      out_grant_has_requester <= (cmd.op == OP_GRANT)   ? has_r :
                                 (cmd.op == OP_HANDOFF) ? sel_has : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_cnt_r <= CNT_W'(WAIT_ENTRIES))
    else $error("wait queue count beyond depth");

  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    do_enq |-> (wait_cnt_r < CNT_W'(WAIT_ENTRIES)))
    else $error("enqueue into full wait queue");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_drop |-> ((wait_cnt_r != '0) && $onehot(wait_sel)))
    else $error("waiter removal without a selected entry");
`endif

endmodule

// File: sv/altwq_ctrl.sv
// controller: request sequencing, decision of the table operation and result handshake
module altwq_ctrl import altwq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    fire;
  op_t     dec_op;
  status_t dec_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    fire       = (state_r == S_UPDATE) && (!out_valid_r || out_ready);
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.update = 1'b0;
    cmd.op     = dec_op;
    cmd.status = dec_status;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        if (fire) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // operation and status from the search flags
  always_comb begin
    dec_op     = OP_NONE;
    dec_status = ST_SQUASH_MISS;
    case (stat.action)
      ACT_LOCK: begin
        if (stat.lock_hit) begin
          if (stat.wait_full) begin
            dec_status = ST_WAIT_FULL;
          end else begin
            dec_op     = OP_ENQUEUE;
            dec_status = ST_QUEUED;
          end
        end else if (stat.lock_free) begin
          dec_op     = OP_GRANT;
          dec_status = ST_GRANTED;
        end else begin
          dec_status = ST_LOCK_FULL;
        end
      end
      ACT_UNLOCK: begin
        if (!stat.lock_hit) begin
          dec_status = ST_UNLOCK_ERR;
        end else if (stat.wait_hit) begin
          dec_op     = OP_HANDOFF;
          dec_status = ST_HANDOFF;
        end else begin
          dec_op     = OP_RELEASE;
          dec_status = ST_RELEASED;
        end
      end
      ACT_SQUASH: begin
        if (stat.squash_hit) begin
          dec_op     = OP_SQUASH;
          dec_status = ST_SQUASHED;
        end
      end
      default: begin
        dec_op     = OP_NONE;
        dec_status = ST_SQUASH_MISS;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SEARCH))
    else $error("accepted beat not followed by search");

  a_search_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |=> (state_r == S_UPDATE))
    else $error("search not followed by update");

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update without result beat");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPDATE) && out_valid_r && !out_ready) |-> (!in_ready && !cmd.update))
    else $error("update taken while result beat stalled");
`endif

endmodule

// File: sv/address_lock_table_wait_queue_core.sv
// Address lock table with arrival-ordered wait queue.
//
// Input channel (in_valid/in_ready): one request per beat, in_action selects
// lock, unlock or squash of a pending lock for in_address; in_requester and
// in_has_requester name the source. Output channel (out_valid/out_ready):
// exactly one result beat per request, in request order, carrying out_status
// and the grant fields (zero unless out_grant_valid).
// Each request passes a registered parallel compare against the lock table
// and the wait queue (S_SEARCH), then S_UPDATE updates the table, compacts
// the queue and loads the result register. A new request is taken in the
// same cycle as the update of the previous one, never while another is
// still searching or waiting to update.
// The result register decouples the sides: a request may be accepted while
// the previous result waits. If the receiver stalls, the next update waits
// for the result register to drain and in_ready stays low meanwhile.
// Reset clears the lock table used bits, the wait queue count and the
// handshake state; table contents need no clearing.
module address_lock_table_wait_queue_core import altwq_pkg::*; #(
  parameter int LOCK_ENTRIES = LOCK_ENTRIES_DEF,
  parameter int WAIT_ENTRIES = WAIT_ENTRIES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int REQ_BITS     = REQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [REQ_BITS-1:0]  in_requester,
  input  logic                 in_has_requester,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_status,
  output logic                 out_grant_valid,
  output logic [ADDR_BITS-1:0] out_grant_address,
  output logic [REQ_BITS-1:0]  out_grant_requester,
  output logic                 out_grant_has_requester
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  altwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  altwq_dp #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .WAIT_ENTRIES (WAIT_ENTRIES),
    .ADDR_BITS    (ADDR_BITS),
    .REQ_BITS     (REQ_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_action               (in_action),
    .in_address              (in_address),
    .in_requester            (in_requester),
    .in_has_requester        (in_has_requester),
    .cmd                     (cmd),
    .stat                    (stat),
    .out_status              (out_status),
    .out_grant_valid         (out_grant_valid),
    .out_grant_address       (out_grant_address),
    .out_grant_requester     (out_grant_requester),
    .out_grant_has_requester (out_grant_has_requester)
  );

endmodule
